// File: rtl/core/psec_pkg.sv
package psec_pkg;

   localparam int POS_W = 24;
   localparam int RSQ_W = 52;
   localparam int ROT_W = 16;
   localparam int SPH_W = 3 * POS_W + RSQ_W;

   typedef enum logic [2:0] {
      CMD_CLEAR     = 3'd0,
      CMD_ADD_EXCL  = 3'd1,
      CMD_ADD_INCL  = 3'd2,
      CMD_TRANSLATE = 3'd3,
      CMD_ROT_ROW   = 3'd4,
      CMD_ATOM      = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_VERDICT = 2'd0,
      STAT_FULL    = 2'd1,
      STAT_ZERO    = 2'd2
   } status_type;

   // One stored sphere as it sits in a memory word.
   typedef struct packed {
      logic signed [POS_W-1:0] cx;
      logic signed [POS_W-1:0] cy;
      logic signed [POS_W-1:0] cz;
      logic [RSQ_W-1:0]        rsq;
   } sphere_type;

   // Scan request from the sequencer to a sphere table.
   typedef struct packed {
      logic                    valid;
      logic signed [POS_W-1:0] px;
      logic signed [POS_W-1:0] py;
      logic signed [POS_W-1:0] pz;
   } probe_type;

   function automatic logic signed [POS_W-1:0] sat24(input logic signed [POS_W+2:0] v);
      logic signed [POS_W+2:0] hi;
      logic signed [POS_W+2:0] lo;
      hi = (POS_W+3)'(8388607);
      lo = -(POS_W+3)'(8388608);
      if (v > hi) return POS_W'(hi);
      else if (v < lo) return POS_W'(lo);
      else return v[POS_W-1:0];
   endfunction

endpackage

// File: rtl/core/psec_table.sv
module psec_table #(
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [CW-1:0]            wr_idx,
   input  psec_pkg::sphere_type     wr_data,
   input  logic [CW-1:0]            count,
   input  psec_pkg::probe_type      probe,
   output logic                     busy,
   output logic                     hit_valid,
   output logic                     hit,
   output logic [AW-1:0]            hit_idx
);

   psec_pkg::sphere_type mem [DEPTH];
   psec_pkg::sphere_type rd_ff;

   logic [CW-1:0] idx_ff, idx_in;
   logic          run_ff, run_in;
   logic          rv_ff;
   logic [AW-1:0] ri_ff;
   logic signed [psec_pkg::POS_W-1:0] px_ff, py_ff, pz_ff;

   logic signed [psec_pkg::POS_W:0] dx_ff, dy_ff, dz_ff;
   logic [psec_pkg::RSQ_W-1:0]      r1_ff;
   logic                            v1_ff;
   logic [AW-1:0]                   i1_ff;
   logic [2*psec_pkg::POS_W+1:0]    sx_ff, sy_ff, sz_ff;
   logic [psec_pkg::RSQ_W-1:0]      r2_ff;
   logic                            v2_ff;
   logic [AW-1:0]                   i2_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx[AW-1:0]] <= wr_data;
      end
      rd_ff <= mem[idx_ff[AW-1:0]];
   end

   always_comb begin
      idx_in = idx_ff;
      run_in = run_ff;
      if (probe.valid) begin
         idx_in = '0;
         run_in = (count != '0);
      end else if (run_ff) begin
         idx_in = idx_ff + CW'(1);
         run_in = ((idx_ff + CW'(1)) < count);
      end
   end

   // Pipeline: read, difference, square, sum and compare.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         idx_ff <= '0;
         rv_ff  <= 1'b0;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         hit_valid <= 1'b0;
      end else begin
         run_ff <= run_in;
         idx_ff <= idx_in;
         rv_ff  <= run_ff;
         v1_ff  <= rv_ff;
         v2_ff  <= v1_ff;
         hit_valid <= v2_ff;
      end
      if (probe.valid) begin
         px_ff <= probe.px;
         py_ff <= probe.py;
         pz_ff <= probe.pz;
      end
      ri_ff <= idx_ff[AW-1:0];
      dx_ff <= (psec_pkg::POS_W+1)'(px_ff) - (psec_pkg::POS_W+1)'(rd_ff.cx);
      dy_ff <= (psec_pkg::POS_W+1)'(py_ff) - (psec_pkg::POS_W+1)'(rd_ff.cy);
      dz_ff <= (psec_pkg::POS_W+1)'(pz_ff) - (psec_pkg::POS_W+1)'(rd_ff.cz);
      r1_ff <= rd_ff.rsq;
      i1_ff <= ri_ff;
      sx_ff <= (2*psec_pkg::POS_W+2)'(dx_ff * dx_ff);
      sy_ff <= (2*psec_pkg::POS_W+2)'(dy_ff * dy_ff);
      sz_ff <= (2*psec_pkg::POS_W+2)'(dz_ff * dz_ff);
      r2_ff <= r1_ff;
      i2_ff <= i1_ff;
      hit   <= ((psec_pkg::RSQ_W)'(sx_ff) + (psec_pkg::RSQ_W)'(sy_ff)
                + (psec_pkg::RSQ_W)'(sz_ff)) <= r2_ff;
      hit_idx <= i2_ff;
   end

   assign busy = run_ff | rv_ff | v1_ff | v2_ff | hit_valid;

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> idx_ff < count) else $error("scan ran past fill count");
   a_hit_follows: assert property (@(posedge clock) disable iff (reset)
      v2_ff |=> hit_valid) else $error("hit pipeline lost a slot");
   a_no_probe_busy: assert property (@(posedge clock) disable iff (reset)
      probe.valid |-> !run_ff) else $error("probe while scanning");

endmodule

// File: rtl/core/pose_sphere_exclusion_check.sv
// Channel | Ports                                  | Handshake
// request | req_command, req_pos_*, req_radius_sq, | start & !busy
//         | req_rot_*, req_row_index, req_last_atom|
// result  | rsp_excluded, rsp_status               | rsp_valid, one cycle
// A table or pose command does not raise busy; a reject is reported the next cycle.
// An atom holds busy through the transform, a scan of max(excl_count, incl_count)
// sphere entries, the drain of the read and compare pipeline and a verdict
// state.
// Reset empties both tables and restores the identity pose; stored spheres
// are not cleared, the fill counts guard them. The receiver cannot stall.
module pose_sphere_exclusion_check #(
   parameter int EXCL_DEPTH = 16,
   parameter int INCL_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_command,
   input  logic signed [23:0] req_pos_x,
   input  logic signed [23:0] req_pos_y,
   input  logic signed [23:0] req_pos_z,
   input  logic [51:0]        req_radius_sq,
   input  logic signed [15:0] req_rot_a,
   input  logic signed [15:0] req_rot_b,
   input  logic signed [15:0] req_rot_c,
   input  logic [1:0]         req_row_index,
   input  logic               req_last_atom,
   output logic               rsp_valid,
   output logic               rsp_excluded,
   output logic [1:0]         rsp_status
);

   localparam int EAW = (EXCL_DEPTH > 1) ? $clog2(EXCL_DEPTH) : 1;
   localparam int IAW = (INCL_DEPTH > 1) ? $clog2(INCL_DEPTH) : 1;
   localparam int ECW = $clog2(EXCL_DEPTH + 1);
   localparam int ICW = $clog2(INCL_DEPTH + 1);
   localparam int PW  = psec_pkg::POS_W;
   localparam int SW  = 42;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_XF   = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [ECW-1:0] ecnt_ff;
   logic [ICW-1:0] icnt_ff;
   logic signed [psec_pkg::ROT_W-1:0] rot_ff [9];
   logic signed [PW-1:0] tr_ff [3];
   logic excl_hit_ff;
   logic [INCL_DEPTH-1:0] mask_ff;
   logic last_ff;
   logic [1:0] ax_ff;
   logic signed [PW-1:0] p_ff [3];
   logic signed [PW-1:0] q_ff [3];
   logic signed [SW-1:0] s;
   logic signed [SW-1:0] sr;
   logic signed [PW+2:0] qs;
   logic accept;
   logic wr_e, wr_i;
   psec_pkg::sphere_type wr_data;
   psec_pkg::probe_type  probe;
   logic e_busy, i_busy, e_hv, i_hv, e_hit, i_hit;
   logic [EAW-1:0] e_idx;
   logic [IAW-1:0] i_idx;
   logic verdict;
   logic [INCL_DEPTH-1:0] live;

   assign accept = start & ~busy;
   assign busy   = (state_ff != ST_IDLE);
   assign wr_data = '{cx: req_pos_x, cy: req_pos_y, cz: req_pos_z, rsq: req_radius_sq};
   assign wr_e = accept && req_command == psec_pkg::CMD_ADD_EXCL && req_radius_sq != '0
                 && ecnt_ff < ECW'(EXCL_DEPTH);
   assign wr_i = accept && req_command == psec_pkg::CMD_ADD_INCL && req_radius_sq != '0
                 && icnt_ff < ICW'(INCL_DEPTH);

   // One output axis per cycle, sharing three multipliers.
   assign s = SW'(rot_ff[ax_ff*3] * p_ff[0]) + SW'(rot_ff[ax_ff*3+1] * p_ff[1])
            + SW'(rot_ff[ax_ff*3+2] * p_ff[2]);
   assign sr = (s + SW'(8192)) >>> 14;
   assign qs = (PW+3)'(sr) + (PW+3)'(tr_ff[ax_ff]);

   assign probe = '{valid: state_ff == ST_XF && ax_ff == 2'd3,
                    px: q_ff[0], py: q_ff[1], pz: q_ff[2]};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept && req_command == psec_pkg::CMD_ATOM) state_in = ST_XF;
         ST_XF:   if (ax_ff == 2'd3) state_in = ST_SCAN;
         ST_SCAN: if (!e_busy && !i_busy) state_in = ST_DONE;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      for (int k = 0; k < INCL_DEPTH; k++) live[k] = (ICW'(k) < icnt_ff);
      verdict = excl_hit_ff | |(live & ~mask_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ecnt_ff <= '0;
         icnt_ff <= '0;
         excl_hit_ff <= 1'b0;
         mask_ff <= '0;
         rsp_valid <= 1'b0;
         for (int k = 0; k < 9; k++) rot_ff[k] <= (k % 4 == 0) ? 16'sd16384 : 16'sd0;
         for (int k = 0; k < 3; k++) tr_ff[k] <= '0;
         ax_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid <= 1'b0;
         if (wr_e) ecnt_ff <= ecnt_ff + ECW'(1);
         if (wr_i) icnt_ff <= icnt_ff + ICW'(1);
         if (accept) begin
            case (req_command)
               psec_pkg::CMD_CLEAR: begin
                  ecnt_ff <= '0;
                  icnt_ff <= '0;
                  excl_hit_ff <= 1'b0;
                  mask_ff <= '0;
               end
               psec_pkg::CMD_ADD_EXCL, psec_pkg::CMD_ADD_INCL: begin
                  if (req_radius_sq == '0) begin
                     rsp_valid <= 1'b1;
                     rsp_status <= psec_pkg::STAT_ZERO;
                     rsp_excluded <= 1'b0;
                  end else if (!wr_e && !wr_i) begin
                     rsp_valid <= 1'b1;
                     rsp_status <= psec_pkg::STAT_FULL;
                     rsp_excluded <= 1'b0;
                  end
               end
               psec_pkg::CMD_TRANSLATE: begin
                  tr_ff[0] <= req_pos_x;
                  tr_ff[1] <= req_pos_y;
                  tr_ff[2] <= req_pos_z;
               end
               psec_pkg::CMD_ROT_ROW: begin
                  if (req_row_index != 2'd3) begin
                     rot_ff[req_row_index*3]   <= req_rot_a;
                     rot_ff[req_row_index*3+1] <= req_rot_b;
                     rot_ff[req_row_index*3+2] <= req_rot_c;
                  end
               end
               psec_pkg::CMD_ATOM: begin
                  ax_ff <= '0;
               end
               default: ;
            endcase
         end
         if (state_ff == ST_XF && ax_ff != 2'd3) ax_ff <= ax_ff + 2'd1;
         if (e_hv && e_hit) excl_hit_ff <= 1'b1;
         if (i_hv && i_hit) mask_ff[i_idx] <= 1'b1;
         if (state_ff == ST_DONE && last_ff) begin
            rsp_valid <= 1'b1;
            rsp_status <= psec_pkg::STAT_VERDICT;
            rsp_excluded <= verdict;
            excl_hit_ff <= 1'b0;
            mask_ff <= '0;
         end
      end
      if (accept) begin
         p_ff[0] <= req_pos_x;
         p_ff[1] <= req_pos_y;
         p_ff[2] <= req_pos_z;
         last_ff <= req_last_atom;
      end
      if (state_ff == ST_XF && ax_ff != 2'd3) q_ff[ax_ff] <= psec_pkg::sat24(qs);
   end

   psec_table #(.DEPTH(EXCL_DEPTH)) u_excl (
      .clock, .reset, .wr_en(wr_e), .wr_idx(ecnt_ff), .wr_data, .count(ecnt_ff),
      .probe, .busy(e_busy), .hit_valid(e_hv), .hit(e_hit), .hit_idx(e_idx));

   psec_table #(.DEPTH(INCL_DEPTH)) u_incl (
      .clock, .reset, .wr_en(wr_i), .wr_idx(icnt_ff), .wr_data, .count(icnt_ff),
      .probe, .busy(i_busy), .hit_valid(i_hv), .hit(i_hit), .hit_idx(i_idx));

   a_cnt_e: assert property (@(posedge clock) disable iff (reset)
      ecnt_ff <= ECW'(EXCL_DEPTH)) else $error("exclusion count overflow");
   a_cnt_i: assert property (@(posedge clock) disable iff (reset)
      icnt_ff <= ICW'(INCL_DEPTH)) else $error("inclusion count overflow");
   a_hit_in_scan: assert property (@(posedge clock) disable iff (reset)
      (e_hv || i_hv) |-> state_ff == ST_SCAN) else $error("hit outside scan");
   a_e_idx: assert property (@(posedge clock) disable iff (reset)
      e_hv |-> ECW'(e_idx) < ecnt_ff) else $error("hit beyond table");

endmodule
